// File: rtl/sdx_pkg.sv
`timescale 1ns / 1ps

package sdx_pkg;

	localparam int QueueDepthDefault = 4;

	localparam int CharWidth  = 8;
	localparam int DigitWidth = 6;
	localparam int CodeWidth  = 3;
	localparam int NumDigits  = 3;
	localparam int OutWidth   = 32;

	localparam logic [CharWidth-1:0]  CharZ     = 8'h5A;
	localparam logic [CharWidth-1:0]  CharUnder = 8'h5F;
	localparam logic [DigitWidth-1:0] DigitZero = 6'd48;
	localparam logic [DigitWidth-1:0] DigitNine = 6'd57;

	localparam logic [CodeWidth-1:0] CodeNone = 3'd0;

	typedef struct packed {
		logic [CharWidth-1:0] upper;
		logic [CodeWidth-1:0] code;
		logic                 underscore;
		logic                 fin;
		logic                 empty;
	} sdx_item_t;

	typedef struct packed {
		logic [DigitWidth-1:0] digit_three;
		logic [DigitWidth-1:0] digit_two;
		logic [DigitWidth-1:0] digit_one;
		logic [CharWidth-1:0]  letter;
	} sdx_code_t;

	function automatic logic [CharWidth-1:0] sdx_upper(input logic [CharWidth-1:0] c);
		logic [CharWidth-1:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic logic [CodeWidth-1:0] sdx_code(input logic [CharWidth-1:0] c,
	                                                  input logic finnish);
		logic [CodeWidth-1:0] r;
		r = CodeNone;
		case (c) inside
			8'h42, 8'h50, 8'h46, 8'h56: r = 3'd1;
			8'h43, 8'h53, 8'h4B, 8'h47,
			8'h4A, 8'h51, 8'h58, 8'h5A: r = 3'd2;
			8'h44, 8'h54:               r = 3'd3;
			8'h4C:                      r = 3'd4;
			8'h4D, 8'h4E:               r = 3'd5;
			8'h52:                      r = 3'd6;
			8'h57:                      r = finnish ? 3'd1 : CodeNone;
			8'hDF, 8'hC7:               r = finnish ? 3'd2 : CodeNone;
			8'hD0, 8'hDE:               r = finnish ? 3'd3 : CodeNone;
			8'hD1:                      r = finnish ? 3'd5 : CodeNone;
			default:                    r = CodeNone;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/sdx_front.sv
`timescale 1ns / 1ps

module sdx_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         s_valid,
	output logic                         s_ready,
	input  logic [sdx_pkg::CharWidth-1:0] s_char,
	input  logic                         s_last,
	input  logic                         s_empty,
	input  logic                         q_full,
	output logic                         push,
	output sdx_pkg::sdx_item_t           push_item
);
	import sdx_pkg::*;

	logic finnish_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finnish_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			finnish_mode_q <= cfg_data;
		end
	end

	assign s_ready = !q_full;
	assign push    = s_valid && !q_full;

	always_comb begin
		push_item.upper      = sdx_upper(s_char);
		push_item.code       = sdx_code(push_item.upper, finnish_mode_q);
		push_item.underscore = (s_char == CharUnder);
		push_item.fin        = s_last || s_empty;
		push_item.empty      = s_empty;
	end

endmodule

// File: rtl/sdx_fifo.sv
`timescale 1ns / 1ps

module sdx_fifo #(
	parameter int DEPTH = sdx_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sdx_pkg::sdx_item_t push_item,
	output logic               full,
	input  logic               pop,
	output sdx_pkg::sdx_item_t pop_item,
	output logic               not_empty
);
	import sdx_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	sdx_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == FullCnt);
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/sdx_back.sv
`timescale 1ns / 1ps

module sdx_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  sdx_pkg::sdx_item_t            q_item,
	output logic                          pop,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic [sdx_pkg::OutWidth-1:0]  m_data
);
	import sdx_pkg::*;

	logic                  pos_q;
	logic [1:0]            filled_q;
	logic [CodeWidth-1:0]  prev_q;
	logic [CharWidth-1:0]  first_q;
	logic [CodeWidth-1:0]  store_q [NumDigits];
	logic [2:0]            sent_cnt_q;
	logic                  sent_broken_q;
	logic                  out_valid_q;
	sdx_code_t             out_code_q;

	logic [1:0]            filled_n;
	logic [CodeWidth-1:0]  prev_n;
	logic [CharWidth-1:0]  first_n;
	logic [CodeWidth-1:0]  store_n [NumDigits];
	logic [2:0]            sent_cnt_n;
	logic                  sent_broken_n;
	logic                  write_digit;
	sdx_code_t             result;

	assign pop     = q_not_empty && (!q_item.fin || !out_valid_q || m_ready);
	assign m_valid = out_valid_q;
	assign m_data  = {(OutWidth - $bits(sdx_code_t))'(0), out_code_q};

	always_comb begin
		filled_n      = filled_q;
		prev_n        = prev_q;
		first_n       = first_q;
		sent_cnt_n    = sent_cnt_q;
		sent_broken_n = sent_broken_q;
		write_digit   = 1'b0;
		if (!pos_q) begin
			first_n       = q_item.upper;
			filled_n      = 2'd0;
			prev_n        = CodeNone;
			sent_cnt_n    = q_item.underscore ? 3'd1 : 3'd0;
			sent_broken_n = !q_item.underscore;
		end else begin
			if (q_item.underscore && sent_cnt_q < 3'd4) begin
				sent_cnt_n = sent_cnt_q + 3'd1;
			end else begin
				sent_broken_n = 1'b1;
			end
			if (filled_q < 2'd3) begin
				if (q_item.code == CodeNone) begin
					prev_n = CodeNone;
				end else if (q_item.code != prev_q) begin
					write_digit = 1'b1;
					filled_n    = filled_q + 2'd1;
					prev_n      = q_item.code;
				end
			end
		end
		for (int k = 0; k < NumDigits; k++) begin
			store_n[k] = (write_digit && filled_q == 2'(k)) ? q_item.code : store_q[k];
		end
	end

	always_comb begin
		if (q_item.empty || (sent_cnt_n == 3'd4 && !sent_broken_n)) begin
			result.letter      = CharZ;
			result.digit_one   = DigitNine;
			result.digit_two   = DigitNine;
			result.digit_three = DigitNine;
		end else begin
			result.letter      = first_n;
			result.digit_one   = (filled_n > 2'd0) ? DigitZero + DigitWidth'(store_n[0])
			                                       : DigitZero;
			result.digit_two   = (filled_n > 2'd1) ? DigitZero + DigitWidth'(store_n[1])
			                                       : DigitZero;
			result.digit_three = (filled_n > 2'd2) ? DigitZero + DigitWidth'(store_n[2])
			                                       : DigitZero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 1'b0;
			filled_q      <= 2'd0;
			prev_q        <= CodeNone;
			first_q       <= '0;
			sent_cnt_q    <= 3'd0;
			sent_broken_q <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int k = 0; k < NumDigits; k++) begin
				store_q[k] <= CodeNone;
			end
		end else begin
			if (pop && q_item.fin) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (q_item.fin) begin
					pos_q <= 1'b0;
				end else begin
					pos_q <= 1'b1;
				end
				filled_q      <= filled_n;
				prev_q        <= prev_n;
				first_q       <= first_n;
				sent_cnt_q    <= sent_cnt_n;
				sent_broken_q <= sent_broken_n;
				for (int k = 0; k < NumDigits; k++) begin
					store_q[k] <= store_n[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.fin) begin
			out_code_q <= result;
		end
	end

endmodule

// File: rtl/soundex_encoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat
// s_axis    in         tdata[7:0] name byte, tlast end of name, tuser empty name
// m_axis    out        tdata[25:0] letter, digit one, digit two, digit three
// cfg       in         cfg_data: 0 English table, 1 Finnish table
//
// One name byte per cycle while the queue is not full; a code appears on m_axis
// in the cycle after its ending byte leaves the queue. An ending byte
// waits at the queue head while an earlier code waits on m_axis_tready; the
// byte queue (QUEUE_DEPTH entries) lets the input keep flowing meanwhile.
// Reset clears the queue, the name state and the table select.

module soundex_encoder #(
	parameter int QUEUE_DEPTH = sdx_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // char_byte
	input  logic                         s_axis_tlast,  // last_byte
	input  logic                         s_axis_tuser,  // empty_name
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// code_letter[7:0], code_digit_one[13:8], code_digit_two[19:14],
	// code_digit_three[25:20], zero pad[31:26]
	output logic [sdx_pkg::OutWidth-1:0] m_axis_tdata
);
	import sdx_pkg::*;

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_not_empty;
	sdx_item_t q_in_item;
	sdx_item_t q_out_item;

	sdx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_char    (s_axis_tdata),
		.s_last    (s_axis_tlast),
		.s_empty   (s_axis_tuser),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_in_item)
	);

	sdx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out_item),
		.not_empty (q_not_empty)
	);

	sdx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (q_out_item),
		.pop         (q_pop),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import sdx_pkg::*;

	typedef enum logic [0:0] {ROW_BEAT, ROW_MODE} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [7:0]          chr;
		logic                last;
		logic                empty;
		logic                typed;
		sdx_code_t           want;
	} dir_row_t;

	localparam int DrainCycles = QueueDepthDefault + 6;
	localparam int PhaseItems  = 110;
	localparam int NumPhases   = 8;

	localparam sdx_code_t NoCode = '0;
	localparam sdx_code_t Z999   = '{DigitNine, DigitNine, DigitNine, CharZ};
	localparam sdx_code_t A000   = '{DigitZero, DigitZero, DigitZero, 8'h41};
	localparam sdx_code_t Nul000 = '{DigitZero, DigitZero, DigitZero, 8'h00};
	localparam sdx_code_t Und000 = '{DigitZero, DigitZero, DigitZero, CharUnder};
	localparam sdx_code_t Ff000  = '{DigitZero, DigitZero, DigitZero, 8'hFF};

	localparam int DirRows = 29;
	localparam dir_row_t DIR_TABLE [DirRows] = '{
		'{ROW_BEAT, 8'hFF, 1'b0, 1'b1, 1'b1, Z999},
		'{ROW_BEAT, "a",   1'b1, 1'b0, 1'b1, A000},
		'{ROW_BEAT, 8'h00, 1'b1, 1'b0, 1'b1, Nul000},
		'{ROW_BEAT, "_",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "_",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "_",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "_",   1'b1, 1'b0, 1'b1, Z999},
		'{ROW_BEAT, "_",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "_",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "_",   1'b1, 1'b0, 1'b1, Und000},
		'{ROW_BEAT, "r",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "o",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "b",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "e",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "r",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "t",   1'b1, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "x",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'h00, 1'b0, 1'b1, 1'b1, Z999},
		'{ROW_BEAT, 8'hFF, 1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "w",   1'b1, 1'b0, 1'b1, Ff000},
		'{ROW_MODE, 8'h01, 1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "a",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'hD1, 1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'hDE, 1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "w",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'hC7, 1'b1, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'hDF, 1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, "x",   1'b0, 1'b0, 1'b0, NoCode},
		'{ROW_BEAT, 8'hD0, 1'b1, 1'b0, 1'b0, NoCode}
	};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic                cfg_data      = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata  = 8'h00;
	logic                s_axis_tlast  = 1'b0;
	logic                s_axis_tuser  = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutWidth-1:0] m_axis_tdata;

	soundex_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	sdx_code_t  pending_codes[$];
	int         err_count = 0;
	bit         idle_on   = 1'b1;
	int         sink_hold = 0;

	bit         fin_mode;
	bit         name_open;
	int         digits_filled;
	logic [2:0] last_code;
	logic [7:0] lead_char;
	logic [2:0] digit_store [3];
	int         under_count;
	bit         under_broken;

	sdx_code_t  got_code;
	sdx_code_t  want_code;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void clear_name();
		name_open      = 1'b0;
		digits_filled  = 0;
		last_code      = CodeNone;
		lead_char      = 8'h00;
		digit_store[0] = CodeNone;
		digit_store[1] = CodeNone;
		digit_store[2] = CodeNone;
		under_count    = 0;
		under_broken   = 1'b0;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= "a" && c <= "z") begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic logic [2:0] letter_code(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			"B", "P", "F", "V":                     r = 3'd1;
			"C", "S", "K", "G", "J", "Q", "X", "Z": r = 3'd2;
			"D", "T":                               r = 3'd3;
			"L":                                    r = 3'd4;
			"M", "N":                               r = 3'd5;
			"R":                                    r = 3'd6;
			default:                                r = CodeNone;
		endcase
		if (r == CodeNone && fin_mode) begin
			case (c)
				"W":          r = 3'd1;
				8'hDF, 8'hC7: r = 3'd2;
				8'hD0, 8'hDE: r = 3'd3;
				8'hD1:        r = 3'd5;
				default:      r = CodeNone;
			endcase
		end
		return r;
	endfunction

	function automatic bit soundex_step(input logic [7:0] chr, input logic last,
	                                    input logic empty, output sdx_code_t code);
		logic [2:0] dig;
		code = NoCode;
		if (empty) begin
			clear_name();
			code = Z999;
			return 1'b1;
		end
		if (!name_open) begin
			clear_name();
			lead_char = fold_case(chr);
			name_open = 1'b1;
		end else if (digits_filled < NumDigits) begin
			dig = letter_code(fold_case(chr));
			if (dig == CodeNone) begin
				last_code = CodeNone;
			end else if (dig != last_code) begin
				digit_store[digits_filled] = dig;
				digits_filled++;
				last_code = dig;
			end
		end
		if (chr == CharUnder && under_count < 4) begin
			under_count++;
		end else begin
			under_broken = 1'b1;
		end
		if (!last) begin
			return 1'b0;
		end
		if (under_count == 4 && !under_broken) begin
			code = Z999;
		end else begin
			code.letter      = lead_char;
			code.digit_one   = digits_filled > 0 ? DigitZero + 6'(digit_store[0]) : DigitZero;
			code.digit_two   = digits_filled > 1 ? DigitZero + 6'(digit_store[1]) : DigitZero;
			code.digit_three = digits_filled > 2 ? DigitZero + 6'(digit_store[2]) : DigitZero;
		end
		clear_name();
		return 1'b1;
	endfunction

	function automatic logic [7:0] pick_name_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 8'($urandom_range(8'h41, 8'h5A));
		end else if (r < 75) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end else if (r < 82) begin
			return CharUnder;
		end else if (r < 90) begin
			case ($urandom_range(0, 6))
				0:       return 8'hDF;
				1:       return 8'hC7;
				2:       return 8'hD0;
				3:       return 8'hDE;
				4:       return 8'hD1;
				5:       return "w";
				default: return "W";
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_beat(input logic [7:0] chr, input logic last, input logic empty,
	                         input logic typed, input sdx_code_t want);
		sdx_code_t code;
		bit        fire;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= chr;
		s_axis_tlast  <= last;
		s_axis_tuser  <= empty;
		do @(posedge clk); while (!s_axis_tready);
		fire = soundex_step(chr, last, empty, code);
		if (fire) begin
			pending_codes.push_back(typed ? want : code);
		end
	endtask

	task automatic set_table(input bit finnish);
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= finnish;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fin_mode = finnish;
	endtask

	task automatic run_names(input int items);
		int sent;
		int kind;
		int len;
		bit unders;
		bit end_empty;
		sent = 0;
		while (sent < items) begin
			kind      = $urandom_range(0, 99);
			unders    = kind < 10;
			end_empty = kind >= 10 && kind < 22;
			if (kind < 5) begin
				len = 4;
			end else if (kind < 10) begin
				len = $urandom_range(1, 6);
			end else if (kind < 16) begin
				len = 0;
			end else if (kind < 22) begin
				len = $urandom_range(1, 4);
			end else if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(8, 14);
			end else begin
				len = $urandom_range(1, 7);
			end
			for (int j = 0; j < len; j++) begin
				send_beat(unders ? CharUnder : pick_name_byte(),
				          j == len - 1 && !end_empty, 1'b0, 1'b0, NoCode);
			end
			if (end_empty) begin
				send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
				          1'b0, NoCode);
			end
			sent += len + (end_empty ? 1 : 0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= sink_hold - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_code = sdx_code_t'(m_axis_tdata[25:0]);
			if (pending_codes.size() == 0) begin
				$error("code beat 0x%0h with none expected", m_axis_tdata);
				err_count++;
			end else begin
				want_code = pending_codes.pop_front();
				check_field("code_letter", want_code.letter, got_code.letter);
				check_field("code_digit_one", want_code.digit_one, got_code.digit_one);
				check_field("code_digit_two", want_code.digit_two, got_code.digit_two);
				check_field("code_digit_three", want_code.digit_three,
				            got_code.digit_three);
				check_field("pad", 0, m_axis_tdata[31:26]);
			end
		end
	end

	initial begin
		fin_mode = 1'b0;
		clear_name();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirRows; i++) begin
			if (DIR_TABLE[i].kind == ROW_MODE) begin
				s_axis_tvalid <= 1'b0;
				set_table(DIR_TABLE[i].chr[0]);
			end else begin
				send_beat(DIR_TABLE[i].chr, DIR_TABLE[i].last, DIR_TABLE[i].empty,
				          DIR_TABLE[i].typed, DIR_TABLE[i].want);
			end
		end
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < NumPhases; p++) begin
			set_table(p[0]);
			idle_on = p != NumPhases - 1;
			run_names(PhaseItems);
		end

		while (pending_codes.size() != 0) @(posedge clk);
		repeat (2 * DrainCycles) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
